FILE: src/meaq_pkg.sv
package meaq_pkg;

  localparam int MAX_SCREENS_DEF  = 2;
  localparam int MAX_MONITORS_DEF = 8;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_COUNT = 2'd1,
    KIND_QUERY = 2'd2
  } kind_t;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_SCR = 2'd1;
  localparam logic [1:0] STATUS_BAD_MON = 2'd2;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
  } rect_t;

  // query in flight along the cell row
  typedef struct packed {
    rect_t              q;
    logic signed [16:0] x1;
    logic signed [16:0] y1;
    logic [2:0]         mon;
    logic [3:0]         cnt;
    logic               left;
    logic               right;
    logic               top;
    logic               bottom;
  } tok_t;

endpackage

FILE: src/meaq_cell.sv
module meaq_cell import meaq_pkg::*; #(
  parameter int IDX         = 0,
  parameter int MAX_SCREENS = MAX_SCREENS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  logic [1:0] wr_scr,
  input  rect_t      wr_rect,
  input  logic [1:0] rd_scr,
  output rect_t      rd_rect,
  input  logic       vld_in,
  input  tok_t       tok_in,
  output logic       vld_out,
  output tok_t       tok_out
);

  localparam int SCR_W = (MAX_SCREENS > 1) ? $clog2(MAX_SCREENS) : 1;

  rect_t mem [MAX_SCREENS];
  rect_t rd_rect_r;
  logic  vld_out_r;
  tok_t  tok_out_r;

  logic signed [16:0] ox, oy, ox1, oy1, qx, qy;
  logic               active, ov_y, ov_x;
  tok_t               tok_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[SCR_W'(wr_scr)] <= wr_rect;
    end
    rd_rect_r <= mem[SCR_W'(rd_scr)];
  end

  always_comb begin
    ox  = {rd_rect_r.x[15], rd_rect_r.x};
    oy  = {rd_rect_r.y[15], rd_rect_r.y};
    ox1 = ox + $signed({2'b00, rd_rect_r.w});
    oy1 = oy + $signed({2'b00, rd_rect_r.h});
    qx  = {tok_in.q.x[15], tok_in.q.x};
    qy  = {tok_in.q.y[15], tok_in.q.y};
    active = (32'(tok_in.cnt) > IDX) && (32'(tok_in.mon) != IDX);
    ov_y = (oy >= qy && oy < tok_in.y1) || (oy1 > qy && oy1 <= tok_in.y1);
    ov_x = (ox >= qx && ox < tok_in.x1) || (ox1 > qx && ox1 <= tok_in.x1);
    tok_nxt = tok_in;
    if (active && ov_y) begin
      if (ox < qx) tok_nxt.left = 1'b0;
      if (ox1 > tok_in.x1) tok_nxt.right = 1'b0;
    end
    if (active && ov_x) begin
      if (oy < qy) tok_nxt.top = 1'b0;
      if (oy1 > tok_in.y1) tok_nxt.bottom = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out_r <= 1'b0;
    end else begin
      vld_out_r <= vld_in;
    end
    tok_out_r <= tok_nxt;
  end

  assign rd_rect = rd_rect_r;
  assign vld_out = vld_out_r;
  assign tok_out = tok_out_r;

endmodule

FILE: src/monitor_edge_adjacency_query_top.sv
// Write and count transactions take effect at the accepting edge; busy stays low.
// A query with a bad screen or monitor reports in the cycle after acceptance.
// A valid query steps through ST_FETCH, where the cell read registers settle on the queried
// screen, and ST_READ, which loads the head token; the token then walks the row of monitor cells.
// One query at a time: busy is high from a valid query's acceptance until its result strobes.
// Synchronous active-low reset clears counts, screen_count to 1; rectangles are not reset.
module monitor_edge_adjacency_query_top import meaq_pkg::*; #(
  parameter int MAX_SCREENS  = MAX_SCREENS_DEF,
  parameter int MAX_MONITORS = MAX_MONITORS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_wdata,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_kind,
  input  logic [1:0]         in_screen_index,
  input  logic [2:0]         in_monitor_index,
  input  logic [3:0]         in_monitor_count,
  input  logic signed [15:0] in_rect_x,
  input  logic signed [15:0] in_rect_y,
  input  logic [14:0]        in_rect_width,
  input  logic [14:0]        in_rect_height,
  output logic               out_valid,
  output logic               out_is_leftmost,
  output logic               out_is_rightmost,
  output logic               out_is_topmost,
  output logic               out_is_bottommost,
  output logic signed [15:0] out_mon_x,
  output logic signed [15:0] out_mon_y,
  output logic [14:0]        out_mon_width,
  output logic [14:0]        out_mon_height,
  output logic [1:0]         out_status
);

  localparam int SCR_W = (MAX_SCREENS > 1) ? $clog2(MAX_SCREENS) : 1;
  localparam int MON_W = (MAX_MONITORS > 1) ? $clog2(MAX_MONITORS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_READ,
    ST_WAIT
  } state_t;

  state_t     state_r;
  logic [1:0] screen_count_r;
  logic [3:0] count_r [MAX_SCREENS];
  logic [1:0] qscr_r;
  logic [2:0] qmon_r;
  logic [3:0] qcnt_r;
  logic       head_vld_r;
  tok_t       head_tok_r;
  logic       out_valid_r;
  logic [3:0] out_flags_r;
  rect_t      out_rect_r;
  logic [1:0] out_status_r;

  logic       accept;
  logic       wr_any;
  logic [3:0] n_sel;
  logic [3:0] cnt_sat;
  logic       scr_bad;
  logic       mon_bad;
  rect_t      wr_rect;
  rect_t      q_sel;

  logic  vld_w [MAX_MONITORS+1];
  tok_t  tok_w [MAX_MONITORS+1];
  rect_t rd_w  [MAX_MONITORS];

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    wr_rect = '{x: in_rect_x, y: in_rect_y, w: in_rect_width, h: in_rect_height};
    wr_any  = accept && (kind_t'(in_kind) == KIND_WRITE)
              && (32'(in_screen_index) < MAX_SCREENS)
              && (32'(in_monitor_index) < MAX_MONITORS);
    n_sel   = count_r[SCR_W'(in_screen_index)];
    scr_bad = (in_screen_index >= screen_count_r) || (32'(in_screen_index) >= MAX_SCREENS);
    mon_bad = ({1'b0, in_monitor_index} >= n_sel);
    cnt_sat = (32'(in_monitor_count) > MAX_MONITORS) ? 4'(MAX_MONITORS) : in_monitor_count;
    q_sel   = rd_w[MON_W'(qmon_r)];
  end

  assign vld_w[0] = head_vld_r;
  assign tok_w[0] = head_tok_r;

  for (genvar i = 0; i < MAX_MONITORS; i++) begin : g_cell
    meaq_cell #(
      .IDX         (i),
      .MAX_SCREENS (MAX_SCREENS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_en   (wr_any && (MON_W'(in_monitor_index) == MON_W'(i))),
      .wr_scr  (in_screen_index),
      .wr_rect (wr_rect),
      .rd_scr  (qscr_r),
      .rd_rect (rd_w[i]),
      .vld_in  (vld_w[i]),
      .tok_in  (tok_w[i]),
      .vld_out (vld_w[i+1]),
      .tok_out (tok_w[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      screen_count_r <= 2'd1;
      for (int s = 0; s < MAX_SCREENS; s++) begin
        count_r[s] <= '0;
      end
      head_vld_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      head_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        screen_count_r <= cfg_wdata;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            unique case (kind_t'(in_kind))
              KIND_COUNT: begin
                if (32'(in_screen_index) < MAX_SCREENS) begin
                  count_r[SCR_W'(in_screen_index)] <= cnt_sat;
                end
              end
              KIND_QUERY: begin
                priority if (scr_bad) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= STATUS_BAD_SCR;
                  out_flags_r  <= 4'b1111;
                  out_rect_r   <= '0;
                end else if (mon_bad) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= STATUS_BAD_MON;
                  out_flags_r  <= 4'b1111;
                  out_rect_r   <= '0;
                end else begin
                  qscr_r  <= in_screen_index;
                  qmon_r  <= in_monitor_index;
                  qcnt_r  <= n_sel;
                  state_r <= ST_FETCH;
                end
              end
              default: begin
                // writes go straight to the cells; unused kind is dropped
              end
            endcase
          end
        end
        ST_FETCH: begin
          // cell read registers settle on the queried screen
          state_r <= ST_READ;
        end
        ST_READ: begin
          head_vld_r        <= 1'b1;
          head_tok_r.q      <= q_sel;
          head_tok_r.x1     <= {q_sel.x[15], q_sel.x} + $signed({2'b00, q_sel.w});
          head_tok_r.y1     <= {q_sel.y[15], q_sel.y} + $signed({2'b00, q_sel.h});
          head_tok_r.mon    <= qmon_r;
          head_tok_r.cnt    <= qcnt_r;
          head_tok_r.left   <= 1'b1;
          head_tok_r.right  <= 1'b1;
          head_tok_r.top    <= 1'b1;
          head_tok_r.bottom <= 1'b1;
          state_r           <= ST_WAIT;
        end
        ST_WAIT: begin
          if (vld_w[MAX_MONITORS]) begin
            out_valid_r  <= 1'b1;
            out_status_r <= STATUS_OK;
            out_flags_r  <= {tok_w[MAX_MONITORS].left, tok_w[MAX_MONITORS].right,
                             tok_w[MAX_MONITORS].top, tok_w[MAX_MONITORS].bottom};
            out_rect_r   <= tok_w[MAX_MONITORS].q;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_is_leftmost   = out_flags_r[3];
  assign out_is_rightmost  = out_flags_r[2];
  assign out_is_topmost    = out_flags_r[1];
  assign out_is_bottommost = out_flags_r[0];
  assign out_mon_x         = out_rect_r.x;
  assign out_mon_y         = out_rect_r.y;
  assign out_mon_width     = out_rect_r.w;
  assign out_mon_height    = out_rect_r.h;
  assign out_status        = out_status_r;

endmodule

FILE: sim/tb_monitor_edge_adjacency_query_top.sv
`timescale 1ns / 1ps

module tb_monitor_edge_adjacency_query_top;
  import meaq_pkg::*;

  localparam int NSCR = MAX_SCREENS_DEF;
  localparam int NMON = MAX_MONITORS_DEF;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam logic [1:0] KIND_IGNORED = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         scr;
    logic [2:0]         mon;
    logic [3:0]         cnt;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
  } cmd_t;

  typedef struct packed {
    logic               leftmost;
    logic               rightmost;
    logic               topmost;
    logic               bottommost;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
    logic [1:0]         status;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_wdata;
  logic start;
  logic busy;
  logic [1:0] in_kind;
  logic [1:0] in_screen_index;
  logic [2:0] in_monitor_index;
  logic [3:0] in_monitor_count;
  logic signed [15:0] in_rect_x;
  logic signed [15:0] in_rect_y;
  logic [14:0] in_rect_width;
  logic [14:0] in_rect_height;
  logic out_valid;
  logic out_is_leftmost;
  logic out_is_rightmost;
  logic out_is_topmost;
  logic out_is_bottommost;
  logic signed [15:0] out_mon_x;
  logic signed [15:0] out_mon_y;
  logic [14:0] out_mon_width;
  logic [14:0] out_mon_height;
  logic [1:0] out_status;

  // mirror of the block's tables and register
  rect_t      panes   [NSCR][NMON];
  bit         written [NSCR][NMON];
  logic [3:0] counts  [NSCR];
  logic [1:0] screens = 2'd1;

  answer_t answers_due[$];
  int errors = 0;
  int sent = 0;
  bit steady = 1'b0;
  int unsigned cycles = 0;

  monitor_edge_adjacency_query_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_screen_index  (in_screen_index),
    .in_monitor_index (in_monitor_index),
    .in_monitor_count (in_monitor_count),
    .in_rect_x        (in_rect_x),
    .in_rect_y        (in_rect_y),
    .in_rect_width    (in_rect_width),
    .in_rect_height   (in_rect_height),
    .out_valid        (out_valid),
    .out_is_leftmost  (out_is_leftmost),
    .out_is_rightmost (out_is_rightmost),
    .out_is_topmost   (out_is_topmost),
    .out_is_bottommost(out_is_bottommost),
    .out_mon_x        (out_mon_x),
    .out_mon_y        (out_mon_y),
    .out_mon_width    (out_mon_width),
    .out_mon_height   (out_mon_height),
    .out_status       (out_status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic cmd_t mk(input logic [1:0] kind, input logic [1:0] scr,
                              input logic [2:0] mon, input logic [3:0] cnt,
                              input logic signed [15:0] x, input logic signed [15:0] y,
                              input logic [14:0] w, input logic [14:0] h);
    cmd_t c;
    c = '{kind: kind, scr: scr, mon: mon, cnt: cnt, x: x, y: y, w: w, h: h};
    return c;
  endfunction

  function automatic string show(input answer_t a);
    return $sformatf("L%0d R%0d T%0d B%0d x=%0d y=%0d w=%0d h=%0d status=%0d",
                     a.leftmost, a.rightmost, a.topmost, a.bottommost,
                     a.x, a.y, a.w, a.h, a.status);
  endfunction

  function automatic int jitter();
    return int'($urandom_range(4)) - 2;
  endfunction

  // Update the mirror for one transaction; return 1 with the answer for a query.
  function automatic bit layout_apply(input cmd_t c, output answer_t a);
    rect_t q;
    rect_t o;
    int qx0, qy0, qx1, qy1, ox0, oy0, ox1, oy1;
    int n;
    a = '0;
    a.leftmost = 1'b1;
    a.rightmost = 1'b1;
    a.topmost = 1'b1;
    a.bottommost = 1'b1;
    a.status = STATUS_OK;
    case (c.kind)
      KIND_WRITE: begin
        if (int'(c.scr) < NSCR && int'(c.mon) < NMON) begin
          panes[c.scr][c.mon] = '{x: c.x, y: c.y, w: c.w, h: c.h};
          written[c.scr][c.mon] = 1'b1;
        end
        return 1'b0;
      end
      KIND_COUNT: begin
        if (int'(c.scr) < NSCR)
          counts[c.scr] = (int'(c.cnt) > NMON) ? 4'(NMON) : c.cnt;
        return 1'b0;
      end
      KIND_QUERY: begin
        if (c.scr >= screens || int'(c.scr) >= NSCR) begin
          a.status = STATUS_BAD_SCR;
          return 1'b1;
        end
        n = int'(counts[c.scr]);
        if (int'(c.mon) >= n) begin
          a.status = STATUS_BAD_MON;
          return 1'b1;
        end
        q = panes[c.scr][c.mon];
        qx0 = $signed(q.x);
        qy0 = $signed(q.y);
        qx1 = qx0 + int'(q.w);
        qy1 = qy0 + int'(q.h);
        for (int i = 0; i < n; i++) begin
          if (i != int'(c.mon)) begin
            o = panes[c.scr][i];
            ox0 = $signed(o.x);
            oy0 = $signed(o.y);
            ox1 = ox0 + int'(o.w);
            oy1 = oy0 + int'(o.h);
            // half-open overlap: an enclosing monitor does not count
            if ((oy0 >= qy0 && oy0 < qy1) || (oy1 > qy0 && oy1 <= qy1)) begin
              if (ox0 < qx0) a.leftmost = 1'b0;
              if (ox1 > qx1) a.rightmost = 1'b0;
            end
            if ((ox0 >= qx0 && ox0 < qx1) || (ox1 > qx0 && ox1 <= qx1)) begin
              if (oy0 < qy0) a.topmost = 1'b0;
              if (oy1 > qy1) a.bottommost = 1'b0;
            end
          end
        end
        a.x = q.x;
        a.y = q.y;
        a.w = q.w;
        a.h = q.h;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // First table entry a query would read before it was ever written, or -1.
  function automatic int unwritten_read(input cmd_t c);
    if (c.kind != KIND_QUERY || c.scr >= screens || int'(c.scr) >= NSCR ||
        {1'b0, c.mon} >= counts[c.scr])
      return -1;
    for (int i = 0; i < int'(counts[c.scr]); i++)
      if (!written[c.scr][i]) return i;
    return -1;
  endfunction

  task automatic issue(input cmd_t c);
    answer_t a;
    if (!steady && $urandom_range(99) < 32) begin
      start <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 16 : 4)) @(posedge clk);
    end
    start            <= 1'b1;
    in_kind          <= c.kind;
    in_screen_index  <= c.scr;
    in_monitor_index <= c.mon;
    in_monitor_count <= c.cnt;
    in_rect_x        <= c.x;
    in_rect_y        <= c.y;
    in_rect_width    <= c.w;
    in_rect_height   <= c.h;
    do @(posedge clk); while (busy !== 1'b0);
    if (layout_apply(c, a))
      answers_due.push_back(a);
    sent++;
  endtask

  task automatic send_cmd(input cmd_t c);
    int hole;
    // fill any entry the query would read before it was ever written
    hole = unwritten_read(c);
    while (hole >= 0) begin
      issue(mk(KIND_WRITE, c.scr, 3'(hole), 4'($urandom), 16'($urandom), 16'($urandom),
               15'($urandom), 15'($urandom)));
      hole = unwritten_read(c);
    end
    issue(c);
  endtask

  task automatic set_screens(input logic [1:0] v);
    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (NMON + 4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we  <= 1'b0;
    screens = v;
  endtask

  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      got = '{out_is_leftmost, out_is_rightmost, out_is_topmost, out_is_bottommost,
              out_mon_x, out_mon_y, out_mon_width, out_mon_height, out_status};
      if (answers_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result with no query pending: %s", $time, show(got));
      end else begin
        want = answers_due.pop_front();
        if (got.leftmost !== want.leftmost || got.rightmost !== want.rightmost ||
            got.topmost !== want.topmost || got.bottommost !== want.bottommost ||
            got.x !== want.x || got.y !== want.y || got.w !== want.w ||
            got.h !== want.h || got.status !== want.status) begin
          errors++;
          if (errors <= 10)
            $display("%0t: query mismatch\n  expected %s\n  actual   %s",
                     $time, show(want), show(got));
        end
      end
    end
  end

  task automatic test_reset_state;
    send_cmd(mk(KIND_QUERY, 2'd0, 3'd0, 4'd0, 0, 0, 0, 0));     // count still zero
    send_cmd(mk(KIND_QUERY, 2'd1, 3'd5, 4'd0, 0, 0, 0, 0));     // only one screen present
    send_cmd(mk(KIND_QUERY, 2'd3, 3'd7, 4'd15, -1, -1, '1, '1));
    send_cmd(mk(KIND_IGNORED, 2'd0, 3'd0, 4'd8, 5, 5, 5, 5));
  endtask

  task automatic test_edge_adjacency;
    set_screens(2'd2);
    // two monitors sharing an edge, a third enclosing both
    send_cmd(mk(KIND_WRITE, 2'd0, 3'd0, 4'd0, 0, 0, 100, 50));
    send_cmd(mk(KIND_WRITE, 2'd0, 3'd1, 4'd0, 100, 0, 100, 50));
    send_cmd(mk(KIND_WRITE, 2'd0, 3'd2, 4'd0, -10, -10, 300, 100));
    send_cmd(mk(KIND_COUNT, 2'd0, 3'd0, 4'd3, 0, 0, 0, 0));
    for (int k = 0; k < 3; k++)
      send_cmd(mk(KIND_QUERY, 2'd0, 3'(k), 4'd0, 0, 0, 0, 0));
    send_cmd(mk(KIND_QUERY, 2'd0, 3'd3, 4'd0, 0, 0, 0, 0));
    // writes to absent screens are dropped
    send_cmd(mk(KIND_WRITE, 2'd2, 3'd0, 4'd0, 7, 7, 7, 7));
    send_cmd(mk(KIND_COUNT, 2'd3, 3'd0, 4'd5, 0, 0, 0, 0));
    send_cmd(mk(KIND_QUERY, 2'd0, 3'd1, 4'd0, 0, 0, 0, 0));
  endtask

  task automatic test_field_extremes;
    send_cmd(mk(KIND_WRITE, 2'd1, 3'd0, 4'd0, -32768, -32768, 32767, 32767));
    send_cmd(mk(KIND_WRITE, 2'd1, 3'd1, 4'd0, 32767, 32767, 32767, 32767));
    send_cmd(mk(KIND_WRITE, 2'd1, 3'd2, 4'd0, 0, 0, 0, 0));
    send_cmd(mk(KIND_WRITE, 2'd1, 3'd3, 4'd0, -1, -1, 1, 1));
    for (int k = 4; k < NMON; k++)
      send_cmd(mk(KIND_WRITE, 2'd1, 3'(k), 4'd0, 16'(k * 1000 - 5000), 16'(5000 - k * 1000),
                  1500, 900));
    send_cmd(mk(KIND_COUNT, 2'd1, 3'd0, 4'd15, 0, 0, 0, 0));  // saturates
    send_cmd(mk(KIND_QUERY, 2'd1, 3'd7, 4'd0, 0, 0, 0, 0));
    send_cmd(mk(KIND_QUERY, 2'd1, 3'd0, 4'd0, 0, 0, 0, 0));
  endtask

  task automatic test_screen_count_limits;
    set_screens(2'd0);
    send_cmd(mk(KIND_QUERY, 2'd0, 3'd0, 4'd0, 0, 0, 0, 0));
    set_screens(2'd3);
    send_cmd(mk(KIND_QUERY, 2'd2, 3'd0, 4'd0, 0, 0, 0, 0));
    send_cmd(mk(KIND_QUERY, 2'd1, 3'd3, 4'd0, 0, 0, 0, 0));
  endtask

  function automatic cmd_t random_cmd();
    cmd_t c;
    int pick;
    pick = $urandom_range(99);
    if (pick < 35) c.kind = KIND_WRITE;
    else if (pick < 45) c.kind = KIND_COUNT;
    else if (pick < 95) c.kind = KIND_QUERY;
    else c.kind = KIND_IGNORED;
    c.scr = ($urandom_range(7) == 0) ? 2'($urandom_range(3)) : 2'($urandom_range(1));
    c.mon = 3'($urandom);
    c.cnt = ($urandom_range(5) == 0) ? 4'($urandom) : 4'($urandom_range(NMON));
    if ($urandom_range(7) == 0) begin
      c.x = 16'($urandom);
      c.y = 16'($urandom);
      c.w = 15'($urandom);
      c.h = 15'($urandom);
    end else begin
      c.x = 16'(int'($urandom_range(120)) - 60);
      c.y = 16'(int'($urandom_range(120)) - 60);
      c.w = 15'($urandom_range(50));
      c.h = 15'($urandom_range(50));
    end
    return c;
  endfunction

  // Tile a screen with near-adjacent monitors, set its count, query each one.
  task automatic layout_burst;
    logic [1:0] s;
    int n, cols, cw, ch;
    s = 2'($urandom_range(1));
    n = $urandom_range(1, NMON);
    cols = $urandom_range(1, 4);
    cw = $urandom_range(4, 40);
    ch = $urandom_range(4, 40);
    for (int k = 0; k < n; k++)
      send_cmd(mk(KIND_WRITE, s, 3'(k), 4'($urandom), 16'((k % cols) * cw + jitter()),
                  16'((k / cols) * ch + jitter()), 15'(cw + jitter()), 15'(ch + jitter())));
    send_cmd(mk(KIND_COUNT, s, 3'd0,
                ($urandom_range(4) == 0) ? 4'($urandom) : 4'(n), 0, 0, 0, 0));
    for (int k = 0; k < n; k++)
      send_cmd(mk(KIND_QUERY, s, 3'(k), 4'd0, 0, 0, 0, 0));
    send_cmd(mk(KIND_QUERY, s, 3'($urandom), 4'd0, 0, 0, 0, 0));
  endtask

  task automatic test_random_traffic;
    logic [1:0] plan [5] = '{2'd2, 2'd1, 2'd2, 2'd2, 2'd3};
    int target;
    for (int p = 0; p < 5; p++) begin
      set_screens(plan[p]);
      steady = (p == 3);
      target = sent + 320;
      while (sent < target) begin
        if ($urandom_range(9) < 3) layout_burst();
        else send_cmd(random_cmd());
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= 2'd0;
    start            <= 1'b0;
    in_kind          <= KIND_WRITE;
    in_screen_index  <= 2'd0;
    in_monitor_index <= 3'd0;
    in_monitor_count <= 4'd0;
    in_rect_x        <= 16'sd0;
    in_rect_y        <= 16'sd0;
    in_rect_width    <= 15'd0;
    in_rect_height   <= 15'd0;
    for (int s = 0; s < NSCR; s++) begin
      counts[s] = 4'd0;
      for (int m = 0; m < NMON; m++) begin
        panes[s][m] = '0;
        written[s][m] = 1'b0;
      end
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_edge_adjacency();
    test_field_extremes();
    test_screen_count_limits();
    test_random_traffic();

    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (NMON + 6) @(posedge clk);
    if (errors == 0 && answers_due.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: files.f
src/meaq_pkg.sv
src/meaq_cell.sv
src/monitor_edge_adjacency_query_top.sv
sim/tb_monitor_edge_adjacency_query_top.sv
